/* rtl/tttd_pkg.sv */
// Shared types, constants and codes for the TTTD content chunker.
// No dependencies; every other file of the block imports this package.
package tttd_pkg;

  // Sliding window depth in bytes (4..64).
  localparam int WIN_BYTES  = 48;
  localparam int FILL_W     = $clog2(WIN_BYTES + 1);

  // Fingerprint modulus 2^14-1, so 2^14 folds to 1.
  localparam int FP_W       = 14;
  localparam logic [FP_W-1:0] FP_MOD = 14'h3fff;
  // 256^WIN_BYTES mod FP_MOD == 2^WIN_SHIFT
  localparam int WIN_SHIFT  = (8 * WIN_BYTES) % FP_W;

  // Remainder unit: one quotient bit per cycle.
  localparam int DIV_STEPS  = FP_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int POS_W      = 32;
  localparam int CHUNK_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_DIVISOR   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_DIVISOR = 8'd3;

  // Register reset values
  localparam logic [CHUNK_W-1:0] MIN_CHUNK_RST      = 16'd460;
  localparam logic [CHUNK_W-1:0] MAX_CHUNK_RST      = 16'd2800;
  localparam logic [FP_W-1:0]    MAIN_DIVISOR_RST   = 14'd540;
  localparam logic [FP_W-1:0]    BACKUP_DIVISOR_RST = 14'd270;

  // Boundary kinds
  localparam logic [1:0] KIND_MAIN   = 2'd0;
  localparam logic [1:0] KIND_BACKUP = 2'd1;
  localparam logic [1:0] KIND_FORCED = 2'd2;
  localparam logic [1:0] KIND_EOF    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] break_pos;
    logic [1:0]       break_kind;
    logic             last_of_run;
    logic             pos_overflow;
  } out_item_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] min_chunk;
    logic [CHUNK_W-1:0] max_chunk;
    logic [FP_W-1:0]    main_divisor;
    logic [FP_W-1:0]    backup_divisor;
  } cfg_t;

  typedef struct packed {
    logic load_in;   // capture the accepted item
    logic res_step;  // window shift, fingerprint and position update
    logic div_load;  // start both remainder units
    logic div_step;  // one remainder bit
    logic dec;       // boundary decision and result push
  } ctrl_cmd_t;

  typedef struct packed {
    logic obuf_empty;
  } ctrl_sts_t;

endpackage

/* rtl/tttd_ctrl.sv */
// Controller FSM of the TTTD chunker: sequences accept, update,
// remainder iterations and decision. Depends on tttd_pkg.
module tttd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tttd_pkg::ctrl_sts_t sts,
  output tttd_pkg::ctrl_cmd_t cmd
);
  import tttd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RES  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DEC  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RES;
        end
      end
      S_RES: begin
        cmd.res_step = 1'b1;
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DEC;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DEC: begin
        // hold until the previous results have drained
        if (sts.obuf_empty) begin
          cmd.dec   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

/* rtl/tttd_rem.sv */
// Restoring remainder unit, one bit per cycle, plus the divisor hit test.
// Depends on tttd_pkg.
module tttd_rem (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [tttd_pkg::FP_W-1:0] dividend,
  input  logic [tttd_pkg::FP_W-1:0] divisor,
  output logic                      hit
);
  import tttd_pkg::*;

  logic [FP_W-1:0] rem_r, rem_nxt;
  logic [FP_W-1:0] quo_r;
  logic [FP_W:0]   trial;
  logic [FP_W:0]   diff;

  assign trial   = {rem_r, quo_r[FP_W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign rem_nxt = (trial >= {1'b0, divisor}) ? diff[FP_W-1:0] : trial[FP_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FP_W-2:0], 1'b0};
    end
  end

  // zero divisor never hits
  assign hit = (divisor != '0) && (rem_r == (divisor - 1'b1));

endmodule

/* rtl/tttd_dpath.sv */
// Datapath of the TTTD chunker: window shift line, fingerprint, position
// registers, two remainder units and a two-entry result queue.
// Depends on tttd_pkg and tttd_rem.
module tttd_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  tttd_pkg::ctrl_cmd_t cmd,
  output tttd_pkg::ctrl_sts_t sts,
  input  tttd_pkg::cfg_t      cfg,
  input  tttd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tttd_pkg::out_item_t out_data
);
  import tttd_pkg::*;

  logic [7:0]       win_r [WIN_BYTES];
  logic [FILL_W-1:0] fill_r;
  logic [FP_W-1:0]  resid_r, resid_nxt;
  logic [FP_W-1:0]  mterm_r, mterm_nxt;
  logic [7:0]       byte_r;
  logic             eof_r;
  logic [POS_W-1:0] pos_r, pos_inc;
  logic [POS_W-1:0] last_r, last_dec;
  logic [POS_W-1:0] bkp_r, bkp_dec, bkp_mid;
  out_item_t        q0_r, q1_r;
  logic [1:0]       qcnt_r, qcnt_nxt;

  logic full;
  assign full = (fill_r == FILL_W'(WIN_BYTES));

  // Weight of the byte leaving the window: old * 2^WIN_SHIFT mod FP_MOD.
  logic [FP_W+7:0] mprod;
  logic [FP_W:0]   mf1, mf1_sub;
  assign mprod     = {{FP_W{1'b0}}, win_r[0]} << WIN_SHIFT;
  assign mf1       = {1'b0, mprod[FP_W-1:0]} + {{(FP_W-7){1'b0}}, mprod[FP_W+7:FP_W]};
  assign mf1_sub   = mf1 - {1'b0, FP_MOD};
  assign mterm_nxt = (mf1 >= {1'b0, FP_MOD}) ? mf1_sub[FP_W-1:0] : mf1[FP_W-1:0];

  // resid*256 mod FP_MOD is a 14-bit rotate by 8.
  logic [FP_W-1:0] rot, sub;
  logic [FP_W+1:0] rsum;
  logic [FP_W:0]   rf1, rf1_sub;
  assign rot  = {resid_r[FP_W-9:0], resid_r[FP_W-1:FP_W-8]};
  assign sub  = full ? mterm_r : '0;
  assign rsum = {2'b00, rot} + {{(FP_W-6){1'b0}}, byte_r} + {2'b00, (FP_MOD - sub)};
  assign rf1  = {1'b0, rsum[FP_W-1:0]} + {{(FP_W-1){1'b0}}, rsum[FP_W+1:FP_W]};
  assign rf1_sub   = rf1 - {1'b0, FP_MOD};
  assign resid_nxt = (rf1 >= {1'b0, FP_MOD}) ? rf1_sub[FP_W-1:0] : rf1[FP_W-1:0];

  assign pos_inc = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  logic main_hit, bkp_hit;

  tttd_rem u_rem_main (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (resid_nxt),
    .divisor  (cfg.main_divisor),
    .hit      (main_hit)
  );

  tttd_rem u_rem_bkp (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (resid_nxt),
    .divisor  (cfg.backup_divisor),
    .hit      (bkp_hit)
  );

  // Boundary decision on the updated position
  logic [POS_W-1:0] span;
  logic             tested, at_max, ovf;
  logic             res_a_vld, res_b_vld;
  out_item_t        res_a, res_b;

  assign span    = pos_r - last_r;
  assign tested  = (span >= {{(POS_W-CHUNK_W){1'b0}}, cfg.min_chunk}) && !(fill_r[0] && !full);
  assign at_max  = (span >= {{(POS_W-CHUNK_W){1'b0}}, cfg.max_chunk});
  assign bkp_mid = (tested && bkp_hit) ? pos_r : bkp_r;
  assign ovf     = (pos_r == '1);

  always_comb begin
    res_a_vld = 1'b0;
    res_a     = '0;
    last_dec  = last_r;
    bkp_dec   = bkp_mid;
    priority if (tested && main_hit) begin
      res_a_vld        = 1'b1;
      res_a.break_pos  = pos_r;
      res_a.break_kind = KIND_MAIN;
      last_dec         = pos_r;
      bkp_dec          = '0;
    end else if (tested && at_max) begin
      res_a_vld = 1'b1;
      if (bkp_mid != '0) begin
        res_a.break_pos  = bkp_mid;
        res_a.break_kind = KIND_BACKUP;
        last_dec         = bkp_mid;
      end else begin
        res_a.break_pos  = pos_r;
        res_a.break_kind = KIND_FORCED;
        last_dec         = pos_r;
      end
      bkp_dec = '0;
    end else begin
      res_a_vld = 1'b0;
    end
    res_b_vld          = eof_r && (last_dec != pos_r);
    res_a.last_of_run  = !res_b_vld;
    res_a.pos_overflow = ovf;
    res_b.break_pos    = pos_r;
    res_b.break_kind   = KIND_EOF;
    res_b.last_of_run  = 1'b1;
    res_b.pos_overflow = ovf;
  end

  // Result queue: push only when empty, so push and pop never meet.
  assign out_valid      = (qcnt_r != 2'd0);
  assign out_data       = q0_r;
  assign sts.obuf_empty = (qcnt_r == 2'd0);

  always_comb begin
    qcnt_nxt = qcnt_r;
    if (cmd.dec) begin
      qcnt_nxt = {1'b0, res_a_vld} + {1'b0, res_b_vld};
    end else if (out_valid && out_ready) begin
      qcnt_nxt = qcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec) begin
      if (res_a_vld) begin
        q0_r <= res_a;
        q1_r <= res_b;
      end else begin
        q0_r <= res_b;
      end
    end else if (out_valid && out_ready) begin
      q0_r <= q1_r;
    end
  end

  always_ff @(posedge clk) begin
    mterm_r <= mterm_nxt;
    if (cmd.load_in) begin
      byte_r <= in_data.data_byte;
      eof_r  <= in_data.end_of_file;
    end
    if (cmd.res_step) begin
      for (int i = 0; i < WIN_BYTES - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_BYTES-1] <= byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      resid_r <= '0;
      pos_r   <= '0;
      last_r  <= '0;
      bkp_r   <= '0;
      qcnt_r  <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (cmd.res_step) begin
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
        resid_r <= resid_nxt;
        pos_r   <= pos_inc;
      end
      if (cmd.dec) begin
        if (eof_r) begin
          // next file starts from scratch
          fill_r  <= '0;
          resid_r <= '0;
          pos_r   <= '0;
          last_r  <= '0;
          bkp_r   <= '0;
        end else begin
          last_r <= last_dec;
          bkp_r  <= bkp_dec;
        end
      end
    end
  end

endmodule

/* rtl/tttd_content_chunker_top.sv */
// TTTD content chunker, top level. Bytes of a file enter one item at a
// time on the in_ channel; each byte produces zero, one or two boundary
// items on the out_ channel (a divisor or max-length boundary, then an
// end-of-file length), the last one flagged by last_of_run. A byte is
// accepted, shifts the window and folds into the mod-16383 fingerprint,
// runs the two bit-serial remainder units (fingerprint mod main and backup
// divisor), then gets its boundary decision; the next byte is accepted only
// after that. The decision waits until the results of the previous byte
// have all been taken, so a slow consumer delays it. Registers are to be
// written through cfg_ only while the block is idle; the block does not
// enforce this, cfg_ready is always high and writes to unknown indexes are
// dropped. No clearing pass follows reset: the window shift line is only
// read once it is full. Depends on tttd_pkg, tttd_ctrl, tttd_dpath.
module tttd_content_chunker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // byte input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tttd_pkg::in_item_t                in_data,
  // boundary output
  output logic                              out_valid,
  input  logic                              out_ready,
  output tttd_pkg::out_item_t               out_data,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tttd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tttd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tttd_pkg::*;

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Register file: values are masked to field width.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_chunk      <= MIN_CHUNK_RST;
      cfg_r.max_chunk      <= MAX_CHUNK_RST;
      cfg_r.main_divisor   <= MAIN_DIVISOR_RST;
      cfg_r.backup_divisor <= BACKUP_DIVISOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_CHUNK:      cfg_r.min_chunk      <= cfg_data[CHUNK_W-1:0];
        CFG_MAX_CHUNK:      cfg_r.max_chunk      <= cfg_data[CHUNK_W-1:0];
        CFG_MAIN_DIVISOR:   cfg_r.main_divisor   <= cfg_data[FP_W-1:0];
        CFG_BACKUP_DIVISOR: cfg_r.backup_divisor <= cfg_data[FP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  tttd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Window, fingerprint, remainder units, decision and result queue
  tttd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/tttd_chk.sv */
// Port-level checker for the TTTD chunker, bound to the top level.
// Depends on tttd_pkg and tttd_content_chunker_top.
module tttd_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input tttd_pkg::out_item_t             out_data
);
  import tttd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // end-of-file boundary always closes the run
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.break_kind == KIND_EOF) |-> out_data.last_of_run)
    else $error("end-of-file boundary not last of run");

  // second item of a run is ready right behind the first
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("run broken after non-last item");

  // one byte at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("byte accepted while busy");

endmodule

bind tttd_content_chunker_top tttd_chk u_chk (.*);
